// File: rtl/core/escd_pkg.sv
`timescale 1ns / 1ps

package escd_pkg;

  localparam int unsigned TsWidth = 32;
  localparam int unsigned DayCntWidth = 16;
  localparam int unsigned SidWidth = 17;
  localparam int unsigned HourRemWidth = 12;

  localparam logic [SidWidth-1:0] SecsPerDay = 17'd86400;
  localparam logic [HourRemWidth-1:0] SecsPerHour = 12'd3600;
  localparam logic [5:0] SecsPerMin = 6'd60;
  localparam logic [2:0] DaysPerWeek = 3'd7;

  // floor(x / d) as (x * recip) >> shift, exact over each operand range
  // day: (ts >> 7) / 675, week: (days + 4) / 7, hour: (sid >> 4) / 225,
  // minute: (rem >> 2) / 15
  localparam logic [25:0] DayRecip = 26'd50903317;
  localparam int unsigned DayShift = 35;
  localparam logic [16:0] WeekRecip = 17'd74899;
  localparam int unsigned WeekShift = 19;
  localparam logic [13:0] HourRecip = 14'd9321;
  localparam int unsigned HourShift = 21;
  localparam logic [10:0] MinRecip = 11'd1093;
  localparam int unsigned MinShift = 14;

  localparam logic [7:0] EpochYearOfs = 8'd70;
  localparam logic [DayCntWidth-1:0] EpochWeekday = 16'd4;
  localparam logic [3:0] LastMonth = 4'd11;
  localparam logic [3:0] February = 4'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DDAY,
    S_DWEEK,
    S_DHOUR,
    S_RHOUR,
    S_DMIN,
    S_LYEAR,
    S_YEAR,
    S_MONTH,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic ld_ts;
    logic div_day;
    logic div_week;
    logic div_hour;
    logic rem_hour;
    logic div_min;
    logic yr_init;
    logic yr_step;
    logic mon_init;
    logic mon_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic year_end;
    logic month_end;
  } status_t;

  // years are kept as offset from 1900; the range only meets 2000 and 2100 as centuries
  function automatic logic is_leap(input logic [7:0] yofs);
    is_leap = (yofs[1:0] == 2'b00) && (yofs != 8'd200);
  endfunction

  function automatic logic [8:0] year_len(input logic [7:0] yofs);
    year_len = is_leap(yofs) ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    case (mon)
      4'd0: month_len = 5'd31;
      February: month_len = leap ? 5'd29 : 5'd28;
      4'd2: month_len = 5'd31;
      4'd3: month_len = 5'd30;
      4'd4: month_len = 5'd31;
      4'd5: month_len = 5'd30;
      4'd6: month_len = 5'd31;
      4'd7: month_len = 5'd31;
      4'd8: month_len = 5'd30;
      4'd9: month_len = 5'd31;
      4'd10: month_len = 5'd30;
      default: month_len = 5'd31;
    endcase
  endfunction

endpackage

// File: rtl/core/escd_dp.sv
`timescale 1ns / 1ps

module escd_dp import escd_pkg::*; (
  input  logic                  clk,
  input  cmd_t                  cmd,
  input  logic [TsWidth-1:0]    in_ts,
  output status_t               status,
  output logic [7:0]            out_years_since_1900,
  output logic [3:0]            out_month_index,
  output logic [4:0]            out_day_of_month,
  output logic [8:0]            out_day_of_year,
  output logic [2:0]            out_weekday,
  output logic [4:0]            out_hour_of_day,
  output logic [5:0]            out_minute_of_hour,
  output logic [5:0]            out_second_of_minute
);

  logic [TsWidth-1:0]      ts_r;
  logic [DayCntWidth-1:0]  days_r;
  logic [SidWidth-1:0]     sid_r;
  logic [13:0]             wq_r;
  logic [2:0]              wday_r;
  logic [4:0]              hour_r;
  logic [HourRemWidth-1:0] mid_r;
  logic [5:0]              min_r;
  logic [5:0]              sec_r;
  logic [DayCntWidth-1:0]  left_r;
  logic [7:0]              yr_r;
  logic [8:0]              yday_r;
  logic [3:0]              mon_r;

  logic [7:0]              years_r;
  logic [3:0]              month_r;
  logic [4:0]              mday_r;
  logic [8:0]              oyday_r;
  logic [2:0]              owday_r;
  logic [4:0]              ohour_r;
  logic [5:0]              omin_r;
  logic [5:0]              osec_r;

  logic [50:0]             day_prod;
  logic [32:0]             day_secs;
  logic [DayCntWidth-1:0]  wk_x;
  logic [32:0]             wk_prod;
  logic [16:0]             wq7;
  logic [26:0]             hr_prod;
  logic [16:0]             hr_secs;
  logic [20:0]             mn_prod;
  logic [11:0]             mn_secs;
  logic [8:0]              ylen;
  logic [4:0]              mlen;

  // reciprocal multiply for the quotient, multiply and subtract for the remainder
  assign day_prod = 51'(ts_r[TsWidth-1:7]) * 51'(DayRecip);
  assign day_secs = 33'(days_r) * 33'(SecsPerDay);
  assign wk_x     = days_r + EpochWeekday;
  assign wk_prod  = 33'(wk_x) * 33'(WeekRecip);
  assign wq7      = 17'(wq_r) * 17'(DaysPerWeek);
  assign hr_prod  = 27'(sid_r[SidWidth-1:4]) * 27'(HourRecip);
  assign hr_secs  = 17'(hour_r) * 17'(SecsPerHour);
  assign mn_prod  = 21'(mid_r[HourRemWidth-1:2]) * 21'(MinRecip);
  assign mn_secs  = 12'(min_r) * 12'(SecsPerMin);

  assign ylen = year_len(yr_r);
  assign mlen = month_len(mon_r, is_leap(yr_r));

  assign status.year_end  = left_r < DayCntWidth'(ylen);
  assign status.month_end = (mon_r == LastMonth) || (left_r < DayCntWidth'(mlen));

  always_ff @(posedge clk) begin
    if (cmd.ld_ts) begin
      ts_r <= in_ts;
    end
    if (cmd.div_day) begin
      days_r <= day_prod[DayShift+DayCntWidth-1:DayShift];
    end
    if (cmd.div_week) begin
      sid_r <= ts_r[SidWidth-1:0] - day_secs[SidWidth-1:0];
      wq_r  <= wk_prod[WeekShift+13:WeekShift];
    end
    if (cmd.div_hour) begin
      wday_r <= wk_x[2:0] - wq7[2:0];
      hour_r <= hr_prod[HourShift+4:HourShift];
    end
    if (cmd.rem_hour) begin
      mid_r <= sid_r[HourRemWidth-1:0] - hr_secs[HourRemWidth-1:0];
    end
    if (cmd.div_min) begin
      min_r <= mn_prod[MinShift+5:MinShift];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.yr_init) begin
      sec_r  <= mid_r[5:0] - mn_secs[5:0];
      left_r <= days_r;
      yr_r   <= EpochYearOfs;
    end else if (cmd.yr_step) begin
      left_r <= left_r - DayCntWidth'(ylen);
      yr_r   <= yr_r + 8'd1;
    end else if (cmd.mon_init) begin
      yday_r <= left_r[8:0];
      mon_r  <= '0;
    end else if (cmd.mon_step) begin
      left_r <= left_r - DayCntWidth'(mlen);
      mon_r  <= mon_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      years_r <= yr_r;
      month_r <= mon_r;
      mday_r  <= left_r[4:0] + 5'd1;
      oyday_r <= yday_r;
      owday_r <= wday_r;
      ohour_r <= hour_r;
      omin_r  <= min_r;
      osec_r  <= sec_r;
    end
  end

  assign out_years_since_1900 = years_r;
  assign out_month_index      = month_r;
  assign out_day_of_month     = mday_r;
  assign out_day_of_year      = oyday_r;
  assign out_weekday          = owday_r;
  assign out_hour_of_day      = ohour_r;
  assign out_minute_of_hour   = omin_r;
  assign out_second_of_minute = osec_r;

endmodule

// File: rtl/core/escd_ctrl.sv
`timescale 1ns / 1ps

module escd_ctrl import escd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_busy;

  assign out_busy = out_valid_r && out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DDAY;
      S_DDAY:   state_nxt = S_DWEEK;
      S_DWEEK:  state_nxt = S_DHOUR;
      S_DHOUR:  state_nxt = S_RHOUR;
      S_RHOUR:  state_nxt = S_DMIN;
      S_DMIN:   state_nxt = S_LYEAR;
      S_LYEAR:  state_nxt = S_YEAR;
      S_YEAR:   if (status.year_end) state_nxt = S_MONTH;
      S_MONTH:  if (status.month_end) state_nxt = S_FINISH;
      S_FINISH: if (!out_busy) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE:   cmd.ld_ts = in_valid;
      S_DDAY:   cmd.div_day = 1'b1;
      S_DWEEK:  cmd.div_week = 1'b1;
      S_DHOUR:  cmd.div_hour = 1'b1;
      S_RHOUR:  cmd.rem_hour = 1'b1;
      S_DMIN:   cmd.div_min = 1'b1;
      S_LYEAR:  cmd.yr_init = 1'b1;
      S_YEAR: begin
        cmd.yr_step  = !status.year_end;
        cmd.mon_init = status.year_end;
      end
      S_MONTH:  cmd.mon_step = !status.month_end;
      S_FINISH: cmd.out_load = !out_busy;
      default:  cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_DDAY))
    else $error("accepted beat did not start the day division");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && !out_busy) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished result not presented");
`endif

endmodule

// File: rtl/core/epoch_seconds_to_calendar_date_unit.sv
`timescale 1ns / 1ps
// from accept to out_valid: day, week, hour and minute divisions, then a step for each
// year after 1970 and each month before the result month, then the result is loaded
// one item at a time; the year and month loops set how far apart items are
// a new beat is taken while the previous result still waits on out_stall
// reset: rst_n synchronous active low clears the controller and out_valid

module epoch_seconds_to_calendar_date_unit import escd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_timestamp_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_years_since_1900,
  output logic [3:0]  out_month_index,
  output logic [4:0]  out_day_of_month,
  output logic [8:0]  out_day_of_year,
  output logic [2:0]  out_weekday,
  output logic [4:0]  out_hour_of_day,
  output logic [5:0]  out_minute_of_hour,
  output logic [5:0]  out_second_of_minute
);

  cmd_t    cmd;
  status_t status;

  escd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  escd_dp u_dp (
    .clk                  (clk),
    .cmd                  (cmd),
    .in_ts                (in_timestamp_seconds),
    .status               (status),
    .out_years_since_1900 (out_years_since_1900),
    .out_month_index      (out_month_index),
    .out_day_of_month     (out_day_of_month),
    .out_day_of_year      (out_day_of_year),
    .out_weekday          (out_weekday),
    .out_hour_of_day      (out_hour_of_day),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_second_of_minute (out_second_of_minute)
  );

endmodule

// File: sim/tb_epoch_seconds_to_calendar_date_unit.sv
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar_date_unit;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned RandomBeats = 700;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned SecsInDay = 86400;
  localparam int unsigned LastDay = 49710;

  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] mday;
    logic [8:0] yday;
    logic [2:0] wday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } cal_date_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_timestamp_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_years_since_1900;
  logic [3:0]  out_month_index;
  logic [4:0]  out_day_of_month;
  logic [8:0]  out_day_of_year;
  logic [2:0]  out_weekday;
  logic [4:0]  out_hour_of_day;
  logic [5:0]  out_minute_of_hour;
  logic [5:0]  out_second_of_minute;

  bit          calm = 1'b0;
  int unsigned idle_cycles = 0;

  logic [31:0] directed_ts[$] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'd86399, 32'd86400, 32'd59, 32'd3599,
    32'd68169600, 32'd68255999, 32'd94694399, 32'd94694400,
    32'd951782400, 32'd951868800, 32'd978220800, 32'd978307199,
    32'd4107456000, 32'd4107542400, 32'd4102444799, 32'd4102444800,
    32'd2147483647, 32'd2147483648, 32'hAAAA_AAAA, 32'h5555_5555,
    32'd1709164799, 32'd1709251199
  };

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  epoch_seconds_to_calendar_date_unit u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_timestamp_seconds (in_timestamp_seconds),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_years_since_1900 (out_years_since_1900),
    .out_month_index      (out_month_index),
    .out_day_of_month     (out_day_of_month),
    .out_day_of_year      (out_day_of_year),
    .out_weekday          (out_weekday),
    .out_hour_of_day      (out_hour_of_day),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_second_of_minute (out_second_of_minute)
  );

  function automatic bit gregorian_leap(int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic cal_date_t calendar_of(logic [31:0] ts);
    int unsigned days;
    int unsigned secs;
    int unsigned left;
    int unsigned yr;
    int unsigned ylen;
    int unsigned mlen;
    int unsigned mi;
    int unsigned common_len[12];
    cal_date_t   d;
    common_len = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    days = ts / SecsInDay;
    secs = ts % SecsInDay;
    left = days;
    yr = 1970;
    forever begin
      ylen = gregorian_leap(yr) ? 366 : 365;
      if (left < ylen) break;
      left -= ylen;
      yr++;
    end
    d.yday = 9'(left);
    for (mi = 0; mi < 11; mi++) begin
      mlen = common_len[mi];
      if (mi == 1 && gregorian_leap(yr)) mlen = 29;
      if (left < mlen) break;
      left -= mlen;
    end
    d.year = 8'(yr - 1900);
    d.month = 4'(mi);
    d.mday = 5'(left + 1);
    d.wday = 3'((days + 4) % 7);
    d.hour = 5'(secs / 3600);
    d.minute = 6'((secs % 3600) / 60);
    d.second = 6'(secs % 60);
    return d;
  endfunction

  class date_scoreboard;
    cal_date_t   pending_dates[$];
    int unsigned mismatches = 0;

    function void note_timestamp(logic [31:0] ts);
      pending_dates.push_back(calendar_of(ts));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s expected %0d actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_date(cal_date_t got);
      cal_date_t want;
      if (pending_dates.size() == 0) begin
        $error("result beat with no timestamp pending");
        mismatches++;
        return;
      end
      want = pending_dates.pop_front();
      compare_field("years_since_1900", 32'(want.year), 32'(got.year));
      compare_field("month_index", 32'(want.month), 32'(got.month));
      compare_field("day_of_month", 32'(want.mday), 32'(got.mday));
      compare_field("day_of_year", 32'(want.yday), 32'(got.yday));
      compare_field("weekday", 32'(want.wday), 32'(got.wday));
      compare_field("hour_of_day", 32'(want.hour), 32'(got.hour));
      compare_field("minute_of_hour", 32'(want.minute), 32'(got.minute));
      compare_field("second_of_minute", 32'(want.second), 32'(got.second));
    endfunction
  endclass

  date_scoreboard sb = new();

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(10);
  endfunction

  // mostly dates near year starts, end of february and day edges
  function automatic logic [31:0] random_timestamp();
    longint unsigned day;
    longint unsigned sec;
    longint unsigned ts;
    int unsigned     yr;
    int unsigned     target;
    int              offs[7];
    offs = '{-1, 0, 58, 59, 60, 364, 365};
    case ($urandom_range(3))
      0: return $urandom();
      1: begin
        day = $urandom_range(LastDay);
      end
      default: begin
        target = $urandom_range(2106, 1970);
        day = 0;
        for (yr = 1970; yr < target; yr++) day += gregorian_leap(yr) ? 366 : 365;
        if (day == 0 && $urandom_range(1)) day = 0;
        else day = longint'(day) + offs[$urandom_range(6)];
      end
    endcase
    case ($urandom_range(2))
      0: sec = 0;
      1: sec = SecsInDay - 1;
      default: sec = $urandom_range(SecsInDay - 1);
    endcase
    ts = day * SecsInDay + sec;
    if (ts > 64'hFFFF_FFFF) ts = 64'hFFFF_FFFF - $urandom_range(SecsInDay);
    return ts[31:0];
  endfunction

  task automatic send_beat(input logic [31:0] ts, input int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_timestamp_seconds <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_timestamp(ts);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.pending_dates.size() > 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_ts[i]) send_beat(directed_ts[i], draw_wait());
    for (int unsigned i = 0; i < RandomBeats; i++) begin
      if (i % 120 == 0) calm = ($urandom_range(2) == 0);
      if (i == RandomBeats / 2) wait_for_results();
      send_beat(random_timestamp(), draw_wait());
    end
    wait_for_results();
    repeat (DrainCycles) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // result side with random backpressure per beat
  initial begin
    int unsigned hold;
    repeat (8) @(posedge clk);
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_date({out_years_since_1900, out_month_index, out_day_of_month,
                     out_day_of_year, out_weekday, out_hour_of_day,
                     out_minute_of_hour, out_second_of_minute});
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: files.f
rtl/core/escd_pkg.sv
rtl/core/escd_dp.sv
rtl/core/escd_ctrl.sv
rtl/core/epoch_seconds_to_calendar_date_unit.sv
sim/tb_epoch_seconds_to_calendar_date_unit.sv
